@@ hdl/sqvg_pkg.sv @@
// ----------------------------------------------------------------------------
// sqvg_pkg
// Shared types, constants and the quarter-wave sine table of the sprite
// quad vertex generator.
// ----------------------------------------------------------------------------
package sqvg_pkg;

    // sine table: entries 0..SIN_ENTRIES cover a quarter turn, Q15
    localparam int SIN_ENTRIES      = 256;
    localparam int SIN_IDX_W        = $clog2(SIN_ENTRIES + 1);
    localparam int SIN_VAL_W        = 16;
    localparam int TRIG_W           = SIN_VAL_W + 1;
    localparam int PHASE_W          = 14;
    localparam int PH_PROD_W        = PHASE_W + SIN_IDX_W;
    localparam longint HALF_PI_Q30  = 64'd1686629713;
    localparam int ONE_Q15          = 32768;

    localparam int VERTS_PER_SPRITE = 4;
    localparam int CORNER_W         = $clog2(VERTS_PER_SPRITE);

    // field widths
    localparam int COORD_W = 24;
    localparam int TEX_W   = 16;
    localparam int WORD_W  = 32;
    localparam int ANGLE_W = 16;

    localparam int S_TDATA_W = 288;
    localparam int M_TDATA_W = 176;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_TEX = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_TEX  = 1'd1;

    typedef enum logic [CORNER_W-1:0] {
        CORNER_BL,
        CORNER_BR,
        CORNER_TR,
        CORNER_TL
    } t_corner;

    typedef logic [SIN_VAL_W-1:0] t_sin_tab [0:SIN_ENTRIES];

    // Taylor series through the x^15 term, all integer, evaluated at elaboration
    function automatic t_sin_tab f_build_sin_tab();
        t_sin_tab    tab;
        logic [63:0] x;
        logic [63:0] t;
        longint      s;
        longint      e;
        int          i;
        int          k;
        for (i = 0; i <= SIN_ENTRIES; i++) begin
            x = (64'(i) * HALF_PI_Q30) / 64'(SIN_ENTRIES);
            t = x;
            s = longint'(x);
            for (k = 1; k <= 7; k++) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = t / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    s = s - longint'(t);
                end else begin
                    s = s + longint'(t);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            e = (s + 16384) >>> 15;
            if (e > ONE_Q15) begin
                e = ONE_Q15;
            end
            tab[i] = SIN_VAL_W'(e);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = f_build_sin_tab();

endpackage

@@ hdl/sprite_quad_vertex_generator.sv @@
// ----------------------------------------------------------------------------
// sprite_quad_vertex_generator
// Expands one sprite request into four rotated, textured quad vertices.
// ----------------------------------------------------------------------------
// One request in, four vertices out (bottom-left, bottom-right, top-right,
// top-left), one vertex per cycle while m_axis_tready does not stall the
// pipe; the next request is taken in the same cycle that the last corner of
// the current one is issued. The corner sequencer owns the single rotate
// datapath for the whole request. Each corner passes the stage 1, stage 2
// and output registers. Sine and cosine come from a quarter-wave Q15 table
// (angle in 1/65536 of a turn); positions and texture coordinates saturate.
// A texture id equal to the null id register is replaced by the white
// texture id. The user must write configuration registers only while no
// request is in flight; the block itself does not enforce this.
module sprite_quad_vertex_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [sqvg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sqvg_pkg::WORD_W-1:0]     i_cfg_wdata,

    // sprite requests
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pos_x[23:0] pos_y[47:24] width[71:48] height[95:72] pivot_dx[119:96]
    // pivot_dy[143:120] angle[159:144] base_u[175:160] base_v[191:176]
    // rgba[223:192] tex_id[255:224] sprite_tag[287:256]
    input  logic [sqvg_pkg::S_TDATA_W-1:0]  s_axis_tdata,

    // vertices
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // vert_x[23:0] vert_y[47:24] vert_u[63:48] vert_v[79:64]
    // vert_rgba[111:80] vert_tex_id[143:112] vert_tag[175:144]
    output logic [sqvg_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast,
    // corner[1:0]
    output logic [sqvg_pkg::CORNER_W-1:0]   m_axis_tuser
);

    import sqvg_pkg::*;

    localparam int TX_W   = COORD_W + 1;          // corner offset from pivot
    localparam int PROD_W = TX_W + TRIG_W;         // one rotate product
    localparam int SUM_W  = PROD_W + 1;            // dot product plus round
    localparam int ROT_W  = SUM_W - 15;            // rotated offset, Q15 removed
    localparam int POS_W  = ROT_W + 1;             // pivot plus offset

    // ------------------------------------------------------------------
    // Field unpacking
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] w_pos_x, w_pos_y, w_width, w_height;
    logic signed [COORD_W-1:0] w_pivot_dx, w_pivot_dy;
    logic        [ANGLE_W-1:0] w_angle;
    logic signed [TEX_W-1:0]   w_base_u, w_base_v;
    logic        [WORD_W-1:0]  w_rgba, w_tex_id, w_tag;

    assign w_pos_x    = s_axis_tdata[23:0];
    assign w_pos_y    = s_axis_tdata[47:24];
    assign w_width    = s_axis_tdata[71:48];
    assign w_height   = s_axis_tdata[95:72];
    assign w_pivot_dx = s_axis_tdata[119:96];
    assign w_pivot_dy = s_axis_tdata[143:120];
    assign w_angle    = s_axis_tdata[159:144];
    assign w_base_u   = s_axis_tdata[175:160];
    assign w_base_v   = s_axis_tdata[191:176];
    assign w_rgba     = s_axis_tdata[223:192];
    assign w_tex_id   = s_axis_tdata[255:224];
    assign w_tag      = s_axis_tdata[287:256];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] r_white_tex, r_null_tex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_tex <= '0;
            r_null_tex  <= '1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_WHITE_TEX: r_white_tex <= i_cfg_wdata;
                CFG_NULL_TEX:  r_null_tex  <= i_cfg_wdata;
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and corner sequencer
    // ------------------------------------------------------------------
    logic    r_busy;
    t_corner r_cnt;
    logic    r1_vld, r2_vld, r_out_vld;
    logic    w_adv;       // whole datapath moves when the output slot frees
    logic    w_issue;     // a corner enters the datapath this cycle
    logic    w_accept;

    assign w_adv         = !r_out_vld || m_axis_tready;
    assign w_issue       = r_busy && w_adv;
    assign s_axis_tready = !r_busy || (w_issue && (r_cnt == CORNER_TL));
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= CORNER_BL;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_cnt  <= CORNER_BL;
            end else if (w_issue) begin
                if (r_cnt == CORNER_TL) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= t_corner'(r_cnt + 1'b1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request register: trig lookup, pivot centre and texture id
    // substitution are settled on acceptance and held for four corners.
    // ------------------------------------------------------------------
    logic        [1:0]          w_quad;
    logic        [PHASE_W-1:0]  w_phase;
    logic        [PH_PROD_W-1:0] w_ph_prod;
    logic        [SIN_IDX_W-1:0] w_idx;
    logic signed [TRIG_W-1:0]   w_s0, w_c0, w_sin, w_cos;

    assign w_quad    = w_angle[ANGLE_W-1 -: 2];
    assign w_phase   = w_angle[PHASE_W-1:0];
    assign w_ph_prod = PH_PROD_W'(w_phase) * PH_PROD_W'(SIN_ENTRIES);
    assign w_idx     = w_ph_prod[PH_PROD_W-1:PHASE_W];
    assign w_s0      = TRIG_W'(SIN_TAB[w_idx]);
    assign w_c0      = TRIG_W'(SIN_TAB[SIN_IDX_W'(SIN_ENTRIES) - w_idx]);

    always_comb begin
        case (w_quad)
            2'd0:    begin w_sin = w_s0;  w_cos = w_c0;  end
            2'd1:    begin w_sin = w_c0;  w_cos = -w_s0; end
            2'd2:    begin w_sin = -w_s0; w_cos = -w_c0; end
            default: begin w_sin = -w_c0; w_cos = w_s0;  end
        endcase
    end

    logic signed [TX_W-1:0]    r_cx, r_cy;
    logic signed [COORD_W-1:0] r_width, r_height, r_pivot_dx, r_pivot_dy;
    logic signed [TRIG_W-1:0]  r_sin, r_cos;
    logic signed [TEX_W-1:0]   r_base_u, r_base_v;
    logic        [WORD_W-1:0]  r_rgba, r_tex, r_tag;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cx       <= TX_W'(w_pos_x) + TX_W'(w_pivot_dx);
            r_cy       <= TX_W'(w_pos_y) + TX_W'(w_pivot_dy);
            r_width    <= w_width;
            r_height   <= w_height;
            r_pivot_dx <= w_pivot_dx;
            r_pivot_dy <= w_pivot_dy;
            r_sin      <= w_sin;
            r_cos      <= w_cos;
            r_base_u   <= w_base_u;
            r_base_v   <= w_base_v;
            r_rgba     <= w_rgba;
            r_tex      <= (w_tex_id == r_null_tex) ? r_white_tex : w_tex_id;
            r_tag      <= w_tag;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: corner offsets, four rotate products, texture coordinates
    // ------------------------------------------------------------------
    function automatic logic signed [TEX_W-1:0] f_sat_tex(
        input logic signed [TEX_W:0] v
    );
        logic signed [TEX_W:0] hi;
        logic signed [TEX_W:0] lo;
        hi = (TEX_W+1)'(2 ** (TEX_W - 1) - 1);
        lo = -hi - (TEX_W+1)'(1);
        if (v > hi) begin
            return TEX_W'(hi);
        end else if (v < lo) begin
            return TEX_W'(lo);
        end
        return TEX_W'(v);
    endfunction

    logic                      w_sel_w, w_sel_h;
    logic signed [TX_W-1:0]    w_tx, w_ty;
    logic signed [TEX_W:0]     w_u_sum, w_v_sum;

    // right-hand corners take the width, top corners the height
    assign w_sel_w = (r_cnt == CORNER_BR) || (r_cnt == CORNER_TR);
    assign w_sel_h = (r_cnt == CORNER_TR) || (r_cnt == CORNER_TL);
    assign w_tx    = (w_sel_w ? TX_W'(r_width)  : '0) - TX_W'(r_pivot_dx);
    assign w_ty    = (w_sel_h ? TX_W'(r_height) : '0) - TX_W'(r_pivot_dy);
    assign w_u_sum = (TEX_W+1)'(r_base_u) + (w_sel_w ? (TEX_W+1)'(256) : '0);
    assign w_v_sum = (TEX_W+1)'(r_base_v) + (w_sel_h ? (TEX_W+1)'(256) : '0);

    logic signed [PROD_W-1:0] r1_xc, r1_ys, r1_xs, r1_yc;
    logic signed [TX_W-1:0]   r1_cx, r1_cy;
    logic signed [TEX_W-1:0]  r1_u, r1_v;
    logic        [WORD_W-1:0] r1_rgba, r1_tex, r1_tag;
    t_corner                  r1_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_xc     <= PROD_W'(w_tx) * PROD_W'(r_cos);
            r1_ys     <= PROD_W'(w_ty) * PROD_W'(r_sin);
            r1_xs     <= PROD_W'(w_tx) * PROD_W'(r_sin);
            r1_yc     <= PROD_W'(w_ty) * PROD_W'(r_cos);
            r1_cx     <= r_cx;
            r1_cy     <= r_cy;
            r1_u      <= f_sat_tex(w_u_sum);
            r1_v      <= f_sat_tex(w_v_sum);
            r1_rgba   <= r_rgba;
            r1_tex    <= r_tex;
            r1_tag    <= r_tag;
            r1_corner <= r_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: dot products, round half up, drop Q15
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] w_sx, w_sy;

    assign w_sx = SUM_W'(r1_xc) - SUM_W'(r1_ys) + SUM_W'(16384);
    assign w_sy = SUM_W'(r1_xs) + SUM_W'(r1_yc) + SUM_W'(16384);

    logic signed [ROT_W-1:0]  r2_rx, r2_ry;
    logic signed [TX_W-1:0]   r2_cx, r2_cy;
    logic signed [TEX_W-1:0]  r2_u, r2_v;
    logic        [WORD_W-1:0] r2_rgba, r2_tex, r2_tag;
    t_corner                  r2_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_rx     <= w_sx[SUM_W-1:15];   // upper bits: floor of /2^15
            r2_ry     <= w_sy[SUM_W-1:15];
            r2_cx     <= r1_cx;
            r2_cy     <= r1_cy;
            r2_u      <= r1_u;
            r2_v      <= r1_v;
            r2_rgba   <= r1_rgba;
            r2_tex    <= r1_tex;
            r2_tag    <= r1_tag;
            r2_corner <= r1_corner;
        end
    end

    // ------------------------------------------------------------------
    // Output register: add pivot, saturate
    // ------------------------------------------------------------------
    function automatic logic signed [COORD_W-1:0] f_sat_pos(
        input logic signed [POS_W-1:0] v
    );
        logic signed [POS_W-1:0] hi;
        logic signed [POS_W-1:0] lo;
        hi = POS_W'(2 ** (COORD_W - 1) - 1);
        lo = -hi - POS_W'(1);
        if (v > hi) begin
            return COORD_W'(hi);
        end else if (v < lo) begin
            return COORD_W'(lo);
        end
        return COORD_W'(v);
    endfunction

    logic signed [POS_W-1:0]   w_vx, w_vy;
    logic signed [COORD_W-1:0] r_out_x, r_out_y;
    logic signed [TEX_W-1:0]   r_out_u, r_out_v;
    logic        [WORD_W-1:0]  r_out_rgba, r_out_tex, r_out_tag;
    t_corner                   r_out_corner;

    assign w_vx = POS_W'(r2_cx) + POS_W'(r2_rx);
    assign w_vy = POS_W'(r2_cy) + POS_W'(r2_ry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_x      <= f_sat_pos(w_vx);
            r_out_y      <= f_sat_pos(w_vy);
            r_out_u      <= r2_u;
            r_out_v      <= r2_v;
            r_out_rgba   <= r2_rgba;
            r_out_tex    <= r2_tex;
            r_out_tag    <= r2_tag;
            r_out_corner <= r2_corner;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_tag, r_out_tex, r_out_rgba,
                            r_out_v, r_out_u, r_out_y, r_out_x};
    assign m_axis_tuser  = r_out_corner;
    assign m_axis_tlast  = (r_out_corner == CORNER_TL);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // a new request may only land while the final corner is issued
    a_accept_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_busy) |-> (w_issue && (r_cnt == CORNER_TL)))
        else $error("request accepted mid-sprite");

    // every issued corner enters stage 1
    a_issue_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> r1_vld)
        else $error("issued corner lost");

    // stage 2 result reaches the output slot when the pipe moves
    a_s2_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_vld && w_adv) |=> r_out_vld)
        else $error("vertex dropped at output");

    // corners stay in order: when stages 1 and 2 both hold a vertex and the one
    // in stage 2 is not the final corner, stage 1 holds the next corner of the quad
    a_corner_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_vld && r2_vld && (r2_corner != CORNER_TL)) |->
        (r1_corner == t_corner'(r2_corner + 1'b1)))
        else $error("corner sequence broken");
`endif

endmodule
